/* rtl/pcrd_pkg.sv */
// ----------------------------------------------------------------------------
// pcrd_pkg
// Shared types and constants for the contact glove record decoder.
// ----------------------------------------------------------------------------
package pcrd_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PLAIN   = 2'd1,
    MODE_STAMPED = 2'd2,
    MODE_TEXT    = 2'd3
  } mode_e;

  localparam logic [7:0]  BYTE_START_PLAIN   = 8'h80;
  localparam logic [7:0]  BYTE_START_STAMPED = 8'h81;
  localparam logic [7:0]  BYTE_START_TEXT    = 8'h82;
  localparam logic [7:0]  BYTE_END           = 8'h8F;
  localparam logic [7:0]  MASK_MAX           = 8'h1F;

  localparam int unsigned NumFingers  = 10;
  localparam int unsigned HandFingers = 5;
  localparam logic [2:0]  PairMax     = 3'd5;
  localparam logic [15:0] TimeoutRst  = 16'd1000;
  localparam logic [15:0] TicksMax    = 16'hFFFF;

  typedef logic [2:0] order_t;
  typedef logic [7:0] byte_t;

endpackage

/* rtl/pcrd_in_if.sv */
// ----------------------------------------------------------------------------
// pcrd_in_if
// Input channel: one received byte or one time tick per transfer.
// ----------------------------------------------------------------------------
interface pcrd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

/* rtl/pcrd_out_if.sv */
// ----------------------------------------------------------------------------
// pcrd_out_if
// Result channel: ten finger touch orders and the record timestamp.
// ----------------------------------------------------------------------------
interface pcrd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  left_thumb;
  logic [2:0]  left_index;
  logic [2:0]  left_middle;
  logic [2:0]  left_ring;
  logic [2:0]  left_little;
  logic [2:0]  right_thumb;
  logic [2:0]  right_index;
  logic [2:0]  right_middle;
  logic [2:0]  right_ring;
  logic [2:0]  right_little;
  logic        has_stamp;
  logic [15:0] stamp;

  modport source (
    output valid, input ready,
    output left_thumb, output left_index, output left_middle, output left_ring,
    output left_little, output right_thumb, output right_index, output right_middle,
    output right_ring, output right_little, output has_stamp, output stamp
  );
  modport sink (
    input valid, output ready,
    input left_thumb, input left_index, input left_middle, input left_ring,
    input left_little, input right_thumb, input right_index, input right_middle,
    input right_ring, input right_little, input has_stamp, input stamp
  );
endinterface

/* rtl/pinch_contact_record_decoder_unit.sv */
// ----------------------------------------------------------------------------
// pinch_contact_record_decoder_unit
// Decodes contact glove records into per-finger touch orders.
// ----------------------------------------------------------------------------
// One input transfer per clock while ready: each byte or tick updates the record
// state in the cycle it is taken, and the end byte of a data record loads the
// result register, which presents it on the next cycle. The input stays ready
// while the result register is empty or being drained, so with a ready sink the
// block sustains one item per cycle. Records that reach timeout_q ticks are
// dropped; text records give nothing.
module pinch_contact_record_decoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  pcrd_in_if.sink             in_i,
  pcrd_out_if.source          out_o
);

  pcrd_pkg::mode_e  mode_q, mode_d;
  pcrd_pkg::byte_t  pend_q [3];
  pcrd_pkg::byte_t  pend_d [3];
  logic [1:0]       pend_cnt_q, pend_cnt_d;
  logic [2:0]       pair_idx_q, pair_idx_d;
  pcrd_pkg::order_t order_q [pcrd_pkg::NumFingers];
  pcrd_pkg::order_t order_d [pcrd_pkg::NumFingers];
  logic [15:0]      elapsed_q, elapsed_d;
  logic [15:0]      timeout_q;

  logic             out_valid_q, out_valid_d;
  pcrd_pkg::order_t res_order_q [pcrd_pkg::NumFingers];
  logic             res_has_q, res_has_d;
  logic [15:0]      res_stamp_q, res_stamp_d;

  logic             accept;
  logic             res_load;
  logic             clear;
  logic             do_pair;
  pcrd_pkg::byte_t  pair_l, pair_r;
  pcrd_pkg::order_t pair_order;
  logic [15:0]      el_inc;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign pair_order = (pair_idx_q < pcrd_pkg::PairMax) ? pair_idx_q + 3'd1 : 3'd0;
  assign el_inc     = (elapsed_q == pcrd_pkg::TicksMax) ? elapsed_q : elapsed_q + 16'd1;

  always_comb begin
    mode_d      = mode_q;
    pend_d      = pend_q;
    pend_cnt_d  = pend_cnt_q;
    pair_idx_d  = pair_idx_q;
    order_d     = order_q;
    elapsed_d   = elapsed_q;
    res_load    = 1'b0;
    res_has_d   = 1'b0;
    res_stamp_d = 16'd0;
    clear       = 1'b0;
    do_pair     = 1'b0;
    pair_l      = pend_q[0];
    pair_r      = in_i.rx_byte;

    if (accept) begin
      if (in_i.kind) begin
        if (mode_q != pcrd_pkg::MODE_IDLE) begin
          elapsed_d = el_inc;
          if (el_inc >= timeout_q) begin
            mode_d = pcrd_pkg::MODE_IDLE;
            clear  = 1'b1;
          end
        end
      end else if (mode_q == pcrd_pkg::MODE_IDLE) begin
        case (in_i.rx_byte)
          pcrd_pkg::BYTE_START_PLAIN: begin
            mode_d = pcrd_pkg::MODE_PLAIN;
            clear  = 1'b1;
          end
          pcrd_pkg::BYTE_START_STAMPED: begin
            mode_d = pcrd_pkg::MODE_STAMPED;
            clear  = 1'b1;
          end
          pcrd_pkg::BYTE_START_TEXT: begin
            mode_d = pcrd_pkg::MODE_TEXT;
            clear  = 1'b1;
          end
          default: ;
        endcase
      end else if (mode_q == pcrd_pkg::MODE_TEXT) begin
        if (in_i.rx_byte == pcrd_pkg::BYTE_END) begin
          mode_d = pcrd_pkg::MODE_IDLE;
          clear  = 1'b1;
        end
      end else if (in_i.rx_byte == pcrd_pkg::BYTE_END) begin
        res_load = 1'b1;
        if (mode_q == pcrd_pkg::MODE_STAMPED && pend_cnt_q >= 2'd2) begin
          res_has_d   = 1'b1;
          res_stamp_d = (pend_cnt_q == 2'd3) ? {pend_q[1], pend_q[2]}
                                             : {pend_q[0], pend_q[1]};
        end
        mode_d = pcrd_pkg::MODE_IDLE;
        clear  = 1'b1;
      end else if (mode_q == pcrd_pkg::MODE_PLAIN) begin
        if (pend_cnt_q == 2'd0) begin
          pend_d[0]  = in_i.rx_byte;
          pend_cnt_d = 2'd1;
        end else begin
          do_pair    = 1'b1;
          pend_cnt_d = 2'd0;
        end
      end else begin
        if (pend_cnt_q == 2'd3) begin
          do_pair    = 1'b1;
          pair_r     = pend_q[1];
          pend_d[0]  = pend_q[2];
          pend_d[1]  = in_i.rx_byte;
          pend_d[2]  = 8'd0;
          pend_cnt_d = 2'd2;
        end else begin
          pend_d[pend_cnt_q] = in_i.rx_byte;
          pend_cnt_d         = pend_cnt_q + 2'd1;
        end
      end
    end

    if (do_pair) begin
      for (int i = 0; i < pcrd_pkg::HandFingers; i++) begin
        if (pair_l <= pcrd_pkg::MASK_MAX && pair_l[pcrd_pkg::HandFingers - 1 - i]) begin
          order_d[i] = pair_order;
        end
        if (pair_r <= pcrd_pkg::MASK_MAX && pair_r[pcrd_pkg::HandFingers - 1 - i]) begin
          order_d[pcrd_pkg::HandFingers + i] = pair_order;
        end
      end
      if (pair_idx_q < pcrd_pkg::PairMax) begin
        pair_idx_d = pair_idx_q + 3'd1;
      end
    end

    if (clear) begin
      for (int i = 0; i < 3; i++) begin
        pend_d[i] = 8'd0;
      end
      for (int i = 0; i < pcrd_pkg::NumFingers; i++) begin
        order_d[i] = 3'd0;
      end
      pend_cnt_d = 2'd0;
      pair_idx_d = 3'd0;
      elapsed_d  = 16'd0;
    end
  end

  assign out_valid_d = res_load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= pcrd_pkg::MODE_IDLE;
      pend_cnt_q  <= 2'd0;
      pair_idx_q  <= 3'd0;
      elapsed_q   <= 16'd0;
      timeout_q   <= pcrd_pkg::TimeoutRst;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pend_q[i] <= 8'd0;
      end
      for (int i = 0; i < pcrd_pkg::NumFingers; i++) begin
        order_q[i] <= 3'd0;
      end
    end else begin
      mode_q      <= mode_d;
      pend_q      <= pend_d;
      pend_cnt_q  <= pend_cnt_d;
      pair_idx_q  <= pair_idx_d;
      order_q     <= order_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_order_q <= order_q;
      res_has_q   <= res_has_d;
      res_stamp_q <= res_stamp_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.left_thumb   = res_order_q[0];
  assign out_o.left_index   = res_order_q[1];
  assign out_o.left_middle  = res_order_q[2];
  assign out_o.left_ring    = res_order_q[3];
  assign out_o.left_little  = res_order_q[4];
  assign out_o.right_thumb  = res_order_q[5];
  assign out_o.right_index  = res_order_q[6];
  assign out_o.right_middle = res_order_q[7];
  assign out_o.right_ring   = res_order_q[8];
  assign out_o.right_little = res_order_q[9];
  assign out_o.has_stamp    = res_has_q;
  assign out_o.stamp        = res_stamp_q;

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_valid_q)
    else $error("input stalled with empty result register");

  a_pair_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_idx_q <= pcrd_pkg::PairMax)
    else $error("pair index beyond saturation");

  a_plain_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == pcrd_pkg::MODE_PLAIN |-> pend_cnt_q <= 2'd1)
    else $error("plain record holds more than one byte");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == pcrd_pkg::MODE_IDLE |->
      (pend_cnt_q == 2'd0 && pair_idx_q == 3'd0 && elapsed_q == 16'd0))
    else $error("record state not cleared while idle");

  a_stamp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_has_q |-> res_stamp_q == 16'd0)
    else $error("stamp nonzero without timestamp");

endmodule

/* dv/tb_pinch_contact_record_decoder_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pinch_contact_record_decoder_unit
// Self-checking bench for the contact glove record decoder. A queue-fed driver
// sends bytes and ticks, a clocked monitor decodes every input transfer with
// its own record tracker and checks each result transfer field by field.
// Runs directed records first, then random record streams under several
// timeout settings and idle patterns, with one long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_pinch_contact_record_decoder_unit;

  localparam realtime     HalfPeriod = 1.0;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned ChunkItems = 230;

  typedef struct packed {
    logic            kind;
    pcrd_pkg::byte_t rx_byte;
  } glove_item_t;

  typedef struct {
    pcrd_pkg::order_t orders [pcrd_pkg::NumFingers];
    logic             has_stamp;
    logic [15:0]      stamp;
  } finger_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  pcrd_in_if  glove_in ();
  pcrd_out_if glove_out ();

  pinch_contact_record_decoder_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (glove_in),
    .out_o       (glove_out)
  );

  always begin
    #(HalfPeriod) clk_i = 1'b1;
    #(HalfPeriod) clk_i = 1'b0;
  end

  glove_item_t    glove_item_q [$];
  finger_report_t finger_report_q [$];
  int unsigned    pushed_items;
  int unsigned    err_cnt;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    hold_req;
  int unsigned    hold_seen;
  int unsigned    hold_left;
  bit             in_taken;
  int unsigned    quiet_cycles;

  string finger_names [pcrd_pkg::NumFingers] = '{
    "left_thumb", "left_index", "left_middle", "left_ring", "left_little",
    "right_thumb", "right_index", "right_middle", "right_ring", "right_little"
  };

  // record tracker
  logic [15:0]      timeout_ticks = pcrd_pkg::TimeoutRst;
  pcrd_pkg::mode_e  rec_mode = pcrd_pkg::MODE_IDLE;
  pcrd_pkg::byte_t  pend_bytes [3];
  logic [1:0]       pend_cnt;
  logic [2:0]       pair_idx;
  pcrd_pkg::order_t cur_orders [pcrd_pkg::NumFingers];
  logic [15:0]      rec_ticks;

  task automatic note_mismatch(string what, logic [15:0] got, logic [15:0] want);
    err_cnt++;
    $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  function automatic void clear_record();
    foreach (pend_bytes[i]) pend_bytes[i] = '0;
    foreach (cur_orders[i]) cur_orders[i] = '0;
    pend_cnt  = '0;
    pair_idx  = '0;
    rec_ticks = '0;
  endfunction

  function automatic void apply_pair(pcrd_pkg::byte_t left, pcrd_pkg::byte_t right);
    pcrd_pkg::order_t ord;
    pcrd_pkg::byte_t  masks [2];
    ord = (pair_idx < pcrd_pkg::PairMax) ? pcrd_pkg::order_t'(pair_idx + 3'd1)
                                         : pcrd_pkg::order_t'(0);
    masks[0] = left;
    masks[1] = right;
    for (int h = 0; h < 2; h++) begin
      if (masks[h] <= pcrd_pkg::MASK_MAX) begin
        for (int b = 0; b < pcrd_pkg::HandFingers; b++) begin
          if (masks[h][b]) begin
            cur_orders[h * pcrd_pkg::HandFingers + pcrd_pkg::HandFingers - 1 - b] = ord;
          end
        end
      end
    end
    if (pair_idx < pcrd_pkg::PairMax) pair_idx++;
  endfunction

  function automatic void decode_glove_item(glove_item_t it);
    finger_report_t rep;
    int             n;
    if (it.kind) begin
      if (rec_mode != pcrd_pkg::MODE_IDLE) begin
        if (rec_ticks != pcrd_pkg::TicksMax) rec_ticks++;
        if (rec_ticks >= timeout_ticks) begin
          rec_mode = pcrd_pkg::MODE_IDLE;
          clear_record();
        end
      end
    end else if (rec_mode == pcrd_pkg::MODE_IDLE) begin
      if (it.rx_byte inside {pcrd_pkg::BYTE_START_PLAIN, pcrd_pkg::BYTE_START_STAMPED,
                             pcrd_pkg::BYTE_START_TEXT}) begin
        case (it.rx_byte)
          pcrd_pkg::BYTE_START_PLAIN:   rec_mode = pcrd_pkg::MODE_PLAIN;
          pcrd_pkg::BYTE_START_STAMPED: rec_mode = pcrd_pkg::MODE_STAMPED;
          default:                      rec_mode = pcrd_pkg::MODE_TEXT;
        endcase
        clear_record();
      end
    end else if (rec_mode == pcrd_pkg::MODE_TEXT) begin
      if (it.rx_byte == pcrd_pkg::BYTE_END) begin
        rec_mode = pcrd_pkg::MODE_IDLE;
        clear_record();
      end
    end else if (it.rx_byte == pcrd_pkg::BYTE_END) begin
      n = int'(pend_cnt);
      rep.orders    = cur_orders;
      rep.has_stamp = 1'b0;
      rep.stamp     = '0;
      if (rec_mode == pcrd_pkg::MODE_STAMPED && n >= 2) begin
        rep.has_stamp = 1'b1;
        rep.stamp     = {pend_bytes[n - 2], pend_bytes[n - 1]};
      end
      finger_report_q.push_back(rep);
      rec_mode = pcrd_pkg::MODE_IDLE;
      clear_record();
    end else if (rec_mode == pcrd_pkg::MODE_PLAIN) begin
      if (pend_cnt == 2'd0) begin
        pend_bytes[0] = it.rx_byte;
        pend_cnt      = 2'd1;
      end else begin
        apply_pair(pend_bytes[0], it.rx_byte);
        pend_cnt = 2'd0;
      end
    end else begin
      if (pend_cnt == 2'd3) begin
        apply_pair(pend_bytes[0], pend_bytes[1]);
        pend_bytes[0] = pend_bytes[2];
        pend_bytes[1] = it.rx_byte;
        pend_bytes[2] = '0;
        pend_cnt      = 2'd2;
      end else begin
        pend_bytes[pend_cnt] = it.rx_byte;
        pend_cnt++;
      end
    end
  endfunction

  task automatic check_report();
    finger_report_t   want;
    pcrd_pkg::order_t got [pcrd_pkg::NumFingers];
    got = '{glove_out.left_thumb, glove_out.left_index, glove_out.left_middle,
            glove_out.left_ring, glove_out.left_little, glove_out.right_thumb,
            glove_out.right_index, glove_out.right_middle, glove_out.right_ring,
            glove_out.right_little};
    if (finger_report_q.size() == 0) begin
      note_mismatch("unexpected result", 16'd1, 16'd0);
      return;
    end
    want = finger_report_q.pop_front();
    for (int f = 0; f < pcrd_pkg::NumFingers; f++) begin
      if (got[f] !== want.orders[f]) begin
        note_mismatch(finger_names[f], 16'(got[f]), 16'(want.orders[f]));
      end
    end
    if (glove_out.has_stamp !== want.has_stamp) begin
      note_mismatch("has_stamp", 16'(glove_out.has_stamp), 16'(want.has_stamp));
    end
    if (glove_out.stamp !== want.stamp) note_mismatch("stamp", glove_out.stamp, want.stamp);
  endtask

  // monitor: sample at the rising edge
  always @(posedge clk_i) begin
    in_taken = 1'b0;
    if (rst_ni) begin
      if (glove_out.valid && glove_out.ready) check_report();
      if (glove_in.valid && glove_in.ready) begin
        decode_glove_item({glove_in.kind, glove_in.rx_byte});
        in_taken = 1'b1;
      end
      if (cfg_we) timeout_ticks = cfg_wdata;
    end
  end

  // byte/tick driver
  always @(negedge clk_i) begin
    glove_item_t nxt;
    if (!rst_ni) begin
      glove_in.valid <= 1'b0;
    end else if (!glove_in.valid || in_taken) begin
      if (glove_item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = glove_item_q.pop_front();
        glove_in.valid   <= 1'b1;
        glove_in.kind    <= nxt.kind;
        glove_in.rx_byte <= nxt.rx_byte;
      end else begin
        glove_in.valid <= 1'b0;
      end
    end
  end

  // result sink with random stalls and long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      glove_out.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      glove_out.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
      glove_out.ready <= 1'b0;
    end else begin
      glove_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((glove_in.valid && glove_in.ready) || (glove_out.valid && glove_out.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_item(logic kind, pcrd_pkg::byte_t b);
    glove_item_t it;
    it.kind    = kind;
    it.rx_byte = b;
    glove_item_q.push_back(it);
    pushed_items++;
  endtask

  task automatic push_bytes(pcrd_pkg::byte_t bs [$]);
    foreach (bs[i]) push_item(1'b0, bs[i]);
  endtask

  function automatic pcrd_pkg::byte_t record_byte();
    pcrd_pkg::byte_t b;
    if ($urandom_range(0, 99) < 85) begin
      b = pcrd_pkg::byte_t'($urandom_range(0, 31));
    end else begin
      do b = pcrd_pkg::byte_t'($urandom); while (b == pcrd_pkg::BYTE_END);
    end
    return b;
  endfunction

  task automatic push_random_records(int unsigned target);
    int unsigned start;
    int unsigned sel;
    int unsigned nbytes;
    bit          stamped;
    start = pushed_items;
    while (pushed_items - start < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        stamped = (sel >= 45);
        push_item(1'b0, stamped ? pcrd_pkg::BYTE_START_STAMPED : pcrd_pkg::BYTE_START_PLAIN);
        nbytes = 2 * $urandom_range(0, ($urandom_range(0, 7) == 0) ? 8 : 4);
        if (stamped && $urandom_range(0, 5) != 0) nbytes += 2;
        if ($urandom_range(0, 5) == 0) nbytes++;
        repeat (nbytes) begin
          push_item(1'b0, record_byte());
          if ($urandom_range(0, 19) == 0) push_item(1'b1, pcrd_pkg::byte_t'($urandom));
        end
        if ($urandom_range(0, 11) != 0) push_item(1'b0, pcrd_pkg::BYTE_END);
      end else if (sel < 88) begin
        push_item(1'b0, pcrd_pkg::BYTE_START_TEXT);
        repeat ($urandom_range(0, 5)) push_item(1'b0, record_byte());
        push_item(1'b0, pcrd_pkg::BYTE_END);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          push_item(1'(($urandom_range(0, 1))), pcrd_pkg::byte_t'($urandom));
        end
      end
    end
    // close whatever is still open so the next setting starts from idle
    push_item(1'b0, pcrd_pkg::BYTE_END);
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #(HalfPeriod / 2);
    end while (glove_item_q.size() != 0 || glove_in.valid || finger_report_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] chunk_timeout [6];
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    glove_in.valid   = 1'b0;
    glove_in.kind    = 1'b0;
    glove_in.rx_byte = '0;
    glove_out.ready  = 1'b0;
    clear_record();
    send_idle_pct = 36;
    recv_idle_pct = 67;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed records at the reset timeout
    push_item(1'b0, pcrd_pkg::BYTE_END);
    push_item(1'b1, 8'h00);
    push_bytes('{pcrd_pkg::BYTE_START_PLAIN, 8'h1F, 8'h00, 8'h01, 8'h1F, 8'h02, 8'h20,
                 8'h04, 8'h08, 8'h08, 8'h10, 8'h1F, 8'h1F, 8'h55});
    push_item(1'b1, 8'hFF);
    push_item(1'b0, pcrd_pkg::BYTE_END);
    push_bytes('{pcrd_pkg::BYTE_START_STAMPED, pcrd_pkg::BYTE_START_PLAIN,
                 pcrd_pkg::BYTE_START_TEXT, 8'h11, 8'hFF, 8'hFF, pcrd_pkg::BYTE_END});
    push_bytes('{pcrd_pkg::BYTE_START_STAMPED, 8'h12, pcrd_pkg::BYTE_END});
    push_bytes('{pcrd_pkg::BYTE_START_TEXT, pcrd_pkg::BYTE_START_STAMPED,
                 pcrd_pkg::BYTE_END});
    wait_idle();

    // shortest timeout: one tick drops the open record
    write_timeout(16'd1);
    push_bytes('{pcrd_pkg::BYTE_START_STAMPED, 8'h05});
    push_item(1'b1, 8'h00);
    push_bytes('{8'h06, pcrd_pkg::BYTE_END});
    wait_idle();

    chunk_timeout = '{16'hFFFF, 16'($urandom_range(2, 20)), 16'd1,
                      16'($urandom_range(20, 300)), 16'hFFFF, 16'($urandom_range(3, 12))};
    for (int c = 0; c < 6; c++) begin
      send_idle_pct = (c < 2) ? 36 : (c < 4) ? 67 : 0;
      recv_idle_pct = (c < 2) ? 67 : (c < 4) ? 36 : 0;
      write_timeout(chunk_timeout[c]);
      push_random_records(ChunkItems);
      if (c == 4) begin
        @(posedge clk_i);
        hold_req++;
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (finger_report_q.size() != 0) begin
      note_mismatch("results missing", 16'(finger_report_q.size()), 16'd0);
    end
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
